// ----- src/lin_slave_header_frame_receiver_top_macros.svh -----
// Assertion macros for the LIN slave header/frame receiver.
// Used by the port checker; needs clk_i and rst_ni in the enclosing scope.
`ifndef LIN_SLAVE_HEADER_FRAME_RECEIVER_TOP_MACROS_SVH
`define LIN_SLAVE_HEADER_FRAME_RECEIVER_TOP_MACROS_SVH

// Checked on every rising edge outside reset
`define LSHFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define LSHFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/lshfr_pkg.sv -----
// Shared types and constants of the LIN slave header/frame receiver.
// No dependencies; imported by all RTL modules and the checker.
package lshfr_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]  SYNC_BYTE         = 8'h55;
  localparam logic [7:0]  TEST_ID           = 8'h42;
  localparam logic [7:0]  RESPONSE_ID_RST   = 8'h2E;
  localparam logic [31:0] PATTERN_A_RST     = 32'hD344_FFBB;
  localparam logic [31:0] PATTERN_B_RST     = 32'h14FD_FF02;
  localparam logic [1:0]  FRAME_DATA_BYTES  = 2'd3;

  // Input actions
  localparam logic ACT_BREAK = 1'b0;
  localparam logic ACT_BYTE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESPONSE_ID = 2'd0,
    CFG_PATTERN_A   = 2'd1,
    CFG_PATTERN_B   = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BREAK = 5'b00010,
    ST_SYNC  = 5'b00100,
    ST_ID    = 5'b01000,
    ST_DATA  = 5'b10000
  } bus_state_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic respond;
    logic frame_done;
    logic frame_which;
    logic frame_match;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  response_id;
    logic [31:0] pattern_a;
    logic [31:0] pattern_b;
  } cfg_t;

endpackage

// ----- src/lshfr_cfg_regs.sv -----
// Configuration registers: response id and the two receive patterns.
// Depends on lshfr_pkg.
module lshfr_cfg_regs
  import lshfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.response_id <= RESPONSE_ID_RST;
      cfg_q.pattern_a   <= PATTERN_A_RST;
      cfg_q.pattern_b   <= PATTERN_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RESPONSE_ID: cfg_q.response_id <= cfg_data_i[7:0];
        CFG_PATTERN_A:   cfg_q.pattern_a   <= cfg_data_i[31:0];
        CFG_PATTERN_B:   cfg_q.pattern_b   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/lshfr_frame_fsm.sv -----
// Bus state machine: break/sync/id tracking and frame capture and compare.
// Depends on lshfr_pkg; one word is consumed per cycle when fire_i is high.
module lshfr_frame_fsm
  import lshfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  bus_state_e  state_q, state_d;
  logic [1:0]  bytes_left_q, bytes_left_d;
  logic [31:0] frame_q, frame_d;
  logic        sel_q, sel_d;

  logic [7:0]  b;
  logic        hit_a, hit_b;
  logic [31:0] pat;

  assign b     = word_i.data_byte;
  assign hit_a = (b == cfg_i.pattern_a[31:24]);
  assign hit_b = (b == cfg_i.pattern_b[31:24]);
  assign pat   = sel_q ? cfg_i.pattern_b : cfg_i.pattern_a;

  // Next state and result
  always_comb begin
    state_d      = state_q;
    bytes_left_d = bytes_left_q;
    frame_d      = frame_q;
    sel_d        = sel_q;
    res_o        = '0;
    if (word_i.action == ACT_BREAK) begin
      bytes_left_d = '0;
      state_d      = ST_BREAK;
    end else begin
      case (state_q)
        ST_BREAK: begin
          bytes_left_d = '0;
          state_d      = ST_SYNC;
        end
        ST_SYNC: begin
          state_d = (b == SYNC_BYTE) ? ST_ID : ST_IDLE;
        end
        ST_ID: begin
          state_d       = ST_IDLE;
          res_o.respond = (b == TEST_ID) || (b == cfg_i.response_id);
          if (hit_a || hit_b) begin
            frame_d      = {b, 24'h0};
            bytes_left_d = FRAME_DATA_BYTES;
            sel_d        = hit_b;
            state_d      = ST_DATA;
          end
        end
        ST_DATA: begin
          bytes_left_d = bytes_left_q - 2'd1;
          case (bytes_left_q)
            2'd3: frame_d[23:16] = b;
            2'd2: frame_d[15:8]  = b;
            2'd1: begin
              frame_d[7:0]      = b;
              state_d           = ST_IDLE;
              res_o.frame_done  = 1'b1;
              res_o.frame_which = sel_q;
              res_o.frame_match = ({frame_q[31:8], b} == pat);
            end
            default: begin
              // nothing left to capture
              bytes_left_d = '0;
              state_d      = ST_IDLE;
            end
          endcase
        end
        default: begin
          // idle: bytes are ignored
          state_d      = ST_IDLE;
          bytes_left_d = '0;
        end
      endcase
    end
    res_valid_o = res_o.respond || res_o.frame_done;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bytes_left_q <= '0;
      sel_q        <= 1'b0;
    end else if (fire_i) begin
      state_q      <= state_d;
      bytes_left_q <= bytes_left_d;
      sel_q        <= sel_d;
    end
  end

  // Captured frame bytes
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      frame_q <= frame_d;
    end
  end

endmodule

// ----- src/lin_slave_header_frame_receiver_top.sv -----
// LIN slave header/frame receiver: input register, state machine, result register.
// Depends on lshfr_pkg, lshfr_cfg_regs and lshfr_frame_fsm.
//
// Takes one word (break event or received byte) per clock unless the input is
// stalled. A word is held in the input register, evaluated by the bus state
// machine once the output register is free or draining, and any result lands
// in the output register; words that give no result leave no output.
// Downstream stall holds the output register and stalls the input only when
// both registers are full.
module lin_slave_header_frame_receiver_top
  import lshfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic      can_adv, fire, in_accept;
  logic      res_valid;
  out_word_t res;

  lshfr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: advance when the output register is free or draining
  assign can_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && can_adv;
  assign in_stall_o = in_valid_q && !can_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  lshfr_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (in_word_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input and output valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (can_adv) begin
        out_valid_q <= fire && res_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- src/lshfr_checker.sv -----
// Port-level assertions for the LIN slave header/frame receiver, bound to the top.
// Depends on lshfr_pkg and the assertion macro header.
`include "lin_slave_header_frame_receiver_top_macros.svh"

module lshfr_checker
  import lshfr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a word is either a respond or a frame completion, never both
  `LSHFR_ASSERT(a_one_kind, out_valid_o |-> !(out_word_o.respond && out_word_o.frame_done), "respond and frame_done together")
  // frame fields only on a frame completion
  `LSHFR_ASSERT(a_frame_fields, (out_valid_o && !out_word_o.frame_done) |-> (!out_word_o.frame_which && !out_word_o.frame_match), "frame fields set without frame_done")
  // input stalls only behind a held result
  `LSHFR_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled with output free")
  // a stalled result holds
  `LSHFR_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)), "stalled result changed")
  // no result once reset has been seen at an edge
  `LSHFR_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind lin_slave_header_frame_receiver_top lshfr_checker u_lshfr_checker (.*);
